// File: rtl/core/deu_pkg.sv
// Package for the digitizer event unpacker: field widths, result codes,
// register indexes and the structs shared by the core, queue and top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package deu_pkg;

  // Largest trace length that a caller may request
  localparam int unsigned MaxTraceLen = 8192;

  // Field widths
  localparam int unsigned WordW   = 16;
  localparam int unsigned IdxW    = 18;
  localparam int unsigned ReqLenW = 14;
  localparam int unsigned KindW   = 2;
  localparam int unsigned EnergyW = 25;
  localparam int unsigned TsW     = 48;
  localparam int unsigned VecW    = 13;
  localparam int unsigned ChanW   = 4;
  localparam int unsigned SampleW = 17;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 14;

  localparam logic [CfgIdxW-1:0] CFG_LAYOUT_NEW   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INVERT_TRACE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_REQ_LEN      = 2'd2;

  // Result kinds
  localparam logic [KindW-1:0] KIND_HEADER    = 2'd0;
  localparam logic [KindW-1:0] KIND_SAMPLE    = 2'd1;
  localparam logic [KindW-1:0] KIND_LEN_ERROR = 2'd2;

  // Trace start word per layout
  localparam logic [IdxW-1:0] TRACE_START_OLD = 18'd12;
  localparam logic [IdxW-1:0] TRACE_START_NEW = 18'd14;

  // Result queue: depth and the fill level at which a new word may enter
  localparam int unsigned QDepth = 8;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = QPtrW + 1;
  localparam logic [QCntW-1:0] QAcceptLimit = QCntW'(QDepth - 2);

  typedef struct packed {
    logic               layout_new;
    logic               invert_trace;
    logic [ReqLenW-1:0] req_len;
  } cfg_t;

  typedef struct packed {
    logic [KindW-1:0]          kind;
    logic [EnergyW-1:0]        energy;
    logic [TsW-1:0]            timestamp;
    logic [VecW-1:0]           vector;
    logic [ChanW-1:0]          channel;
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } res_t;

  // Up to two results produced by one word, in output order
  typedef struct packed {
    logic push0;
    logic push1;
    res_t res0;
    res_t res1;
  } push_t;

endpackage

`default_nettype wire

// File: rtl/core/deu_ifs.sv
// Handshake channels of the digitizer event unpacker: input words,
// results and configuration writes. Depends on deu_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface deu_in_if
  import deu_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [WordW-1:0]  data_word;

  modport source (output valid, output data_word, input ready);
  modport sink   (input valid, input data_word, output ready);
endinterface

interface deu_out_if
  import deu_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic [KindW-1:0]          kind;
  logic [EnergyW-1:0]        energy;
  logic [TsW-1:0]            timestamp;
  logic [VecW-1:0]           vector;
  logic [ChanW-1:0]          channel;
  logic signed [SampleW-1:0] sample;
  logic                      last;

  modport source (output valid, output kind, output energy, output timestamp,
                  output vector, output channel, output sample, output last,
                  input ready);
  modport sink   (input valid, input kind, input energy, input timestamp,
                  input vector, input channel, input sample, input last,
                  output ready);
endinterface

interface deu_cfg_if
  import deu_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/deu_core.sv
// Word decoder of the digitizer event unpacker: input register, event
// position state, header capture and trace decode. Depends on deu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module deu_core
  import deu_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             word_accept,
  input  wire logic [WordW-1:0] word_data,
  output logic                  stage_busy,
  output push_t                 push
);

  // Input register
  logic             in_valid_r;
  logic [WordW-1:0] in_word_r;

  // Event position and per-event state
  logic [IdxW-1:0]  word_index_r, word_index_nxt;
  logic [IdxW-1:0]  event_words_r, event_words_nxt;
  logic [IdxW-1:0]  trace_words_r, trace_words_nxt;
  logic             lay_q_r, lay_q_nxt;
  logic             inv_q_r, inv_q_nxt;
  logic [WordW-1:0] pending_word_r, pending_word_nxt;
  logic [WordW-1:0] hdr_r [0:5];

  // Header decode
  logic [WordW-1:0]   h0, h1;
  logic [21:0]        raw_old;
  logic [EnergyW-1:0] raw_new, mag;
  logic [IdxW-1:0]    len, len_raw, start_hdr, avail, k_pre, k_fin;
  logic [IdxW:0]      k_even;
  logic               len_err;
  logic [VecW-1:0]    vec;
  logic [ChanW-1:0]   chan;

  // Trace decode
  logic [IdxW-1:0]           start_tr, j;
  logic [IdxW:0]             wtot, idx_inc;
  logic                      in_trace;
  logic signed [SampleW-1:0] smp_cur, smp_pend;

  assign stage_busy = in_valid_r;

  // Decode one trace word with the latched layout and inversion
  function automatic logic signed [SampleW-1:0] decode_word(
    input logic [WordW-1:0] w,
    input logic             lay,
    input logic             inv
  );
    logic signed [SampleW-1:0] s;
    if (lay) begin
      s = SampleW'($signed(w));
    end else begin
      s = $signed({5'd0, w[11], 11'd0}) - $signed({6'd0, w[10:0]});
    end
    if (inv) begin
      s = -s;
    end
    return s;
  endfunction

  // Header fields; word 7 is the word in the input register
  always_comb begin
    h0      = hdr_r[0];
    h1      = hdr_r[1];
    raw_old = {in_word_r[5:0], hdr_r[4]};
    raw_new = {in_word_r[8:0], hdr_r[4]};
    if (cfg.layout_new) begin
      mag       = raw_new[EnergyW-1] ? (~raw_new + 25'd1) : raw_new;
      vec       = {8'd0, h0[15:11]};
      chan      = h1[3:0];
      len_raw   = {7'd0, h0[9:0], 1'b0} + 18'd2;
      start_hdr = TRACE_START_NEW;
      k_pre     = {4'd0, cfg.req_len};
    end else begin
      mag       = {3'd0, raw_old[21] ? (~raw_old + 22'd1) : raw_old};
      vec       = h1[15:3];
      chan      = {1'b0, h1[2:0]};
      len_raw   = {1'b0, h0, 1'b0} + 18'd2;
      start_hdr = TRACE_START_OLD;
      k_pre     = (h0 >= 16'd7) ? ({1'b0, h0, 1'b0} - 18'd14) : '0;
    end
    len     = (len_raw < 18'd8) ? 18'd8 : len_raw;
    avail   = (len > start_hdr) ? (len - start_hdr) : '0;
    len_err = ({4'd0, cfg.req_len} > IdxW'(MaxTraceLen));
    k_even  = {1'b0, k_pre} + {{IdxW{1'b0}}, k_pre[0]};
    if (len_err) begin
      k_fin = '0;
    end else if (k_even > {1'b0, avail}) begin
      k_fin = avail;
    end else begin
      k_fin = k_pre;
    end
  end

  // Trace position and samples
  always_comb begin
    start_tr = lay_q_r ? TRACE_START_NEW : TRACE_START_OLD;
    j        = word_index_r - start_tr;
    wtot     = {1'b0, trace_words_r} + {{IdxW{1'b0}}, trace_words_r[0]};
    in_trace = (word_index_r > 18'd7) && (word_index_r >= start_tr) &&
               ({1'b0, j} < wtot);
    smp_cur  = decode_word(in_word_r, lay_q_r, inv_q_r);
    smp_pend = decode_word(pending_word_r, lay_q_r, inv_q_r);
    idx_inc  = {1'b0, word_index_r} + 19'd1;
  end

  // Results and next state for the word in the input register
  always_comb begin
    push             = '0;
    word_index_nxt   = word_index_r;
    event_words_nxt  = event_words_r;
    trace_words_nxt  = trace_words_r;
    lay_q_nxt        = lay_q_r;
    inv_q_nxt        = inv_q_r;
    pending_word_nxt = pending_word_r;
    if (in_valid_r) begin
      if (word_index_r == 18'd7) begin
        lay_q_nxt              = cfg.layout_new;
        inv_q_nxt              = cfg.invert_trace;
        event_words_nxt        = len;
        trace_words_nxt        = k_fin;
        push.push0             = 1'b1;
        push.res0.kind         = KIND_HEADER;
        push.res0.energy       = mag;
        push.res0.timestamp    = {hdr_r[5], hdr_r[2], hdr_r[3]};
        push.res0.vector       = vec;
        push.res0.channel      = chan;
        push.res0.last         = (k_fin == '0) && !len_err;
        if (len_err) begin
          push.push1      = 1'b1;
          push.res1.kind  = KIND_LEN_ERROR;
          push.res1.last  = 1'b1;
        end
      end else if (in_trace) begin
        if (!j[0]) begin
          pending_word_nxt = in_word_r;
        end else begin
          push.push0       = 1'b1;
          push.res0.kind   = KIND_SAMPLE;
          push.res0.sample = smp_cur;
          push.res0.last   = (j == trace_words_r);
          if (j < trace_words_r) begin
            push.push1       = 1'b1;
            push.res1.kind   = KIND_SAMPLE;
            push.res1.sample = smp_pend;
            push.res1.last   = (j + 18'd1 == trace_words_r);
          end
        end
      end
      // Advance or wrap at the event end; word 7 sees the new length
      if ((word_index_r >= 18'd7) &&
          (idx_inc >= {1'b0, (word_index_r == 18'd7) ? len : event_words_r})) begin
        word_index_nxt = '0;
      end else begin
        word_index_nxt = idx_inc[IdxW-1:0];
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      word_index_r   <= '0;
      event_words_r  <= '0;
      trace_words_r  <= '0;
      lay_q_r        <= 1'b1;
      inv_q_r        <= 1'b0;
      pending_word_r <= '0;
    end else begin
      in_valid_r     <= word_accept;
      word_index_r   <= word_index_nxt;
      event_words_r  <= event_words_nxt;
      trace_words_r  <= trace_words_nxt;
      lay_q_r        <= lay_q_nxt;
      inv_q_r        <= inv_q_nxt;
      pending_word_r <= pending_word_nxt;
    end
  end

  // Input word and header capture
  always_ff @(posedge clk) begin
    if (word_accept) begin
      in_word_r <= word_data;
    end
    if (in_valid_r && (word_index_r < 18'd6)) begin
      hdr_r[word_index_r[2:0]] <= in_word_r;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/deu_result_fifo.sv
// Result queue of the digitizer event unpacker: takes up to two results a
// cycle and hands out one per output transfer. Depends on deu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module deu_result_fifo
  import deu_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire push_t        push,
  input  wire logic         pop,
  output logic              not_empty,
  output res_t              head,
  output logic [QCntW-1:0]  count
);

  res_t              mem_r [0:QDepth-1];
  logic [QPtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0]  count_r, count_nxt;
  logic [QPtrW-1:0]  wr_ptr_p1;
  logic [1:0]        n_push;

  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign count     = count_r;

  // Pointer and fill level update
  always_comb begin
    n_push     = {1'b0, push.push0} + {1'b0, push.push1};
    wr_ptr_p1  = wr_ptr_r + QPtrW'(1);
    wr_ptr_nxt = wr_ptr_r + QPtrW'(n_push);
    rd_ptr_nxt = pop ? (rd_ptr_r + QPtrW'(1)) : rd_ptr_r;
    count_nxt  = count_r + QCntW'(n_push) - QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store results in order; the second goes behind the first
  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.push1) begin
      mem_r[wr_ptr_p1] <= push.res1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/digitizer_event_unpacker_unit.sv
// Digitizer event unpacker, top level: configuration registers, word
// decoder and result queue. Depends on deu_pkg, deu_ifs, deu_core, deu_result_fifo.
// Results are decoded from the input register and registered in the result queue.
// Throughput: one word per cycle while the result queue has room; each word
// yields at most two results, which leave at one per output transfer.
// Reset: synchronous active-low rst_n clears the event position, the queue
// and sets the registers to layout_new = 1, invert_trace = 0, length 0.
`timescale 1ns / 1ps
`default_nettype none

module digitizer_event_unpacker_unit
  import deu_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  deu_in_if.sink      in_ch,
  deu_out_if.source   out_ch,
  deu_cfg_if.sink     cfg_ch
);

  cfg_t              cfg_r;
  logic              word_accept;
  logic              stage_busy;
  push_t             push;
  logic              q_not_empty;
  res_t              q_head;
  logic [QCntW-1:0]  q_count;
  logic [QCntW-1:0]  q_reserved;

  // Configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.layout_new   <= 1'b1;
      cfg_r.invert_trace <= 1'b0;
      cfg_r.req_len      <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_LAYOUT_NEW:   cfg_r.layout_new   <= cfg_ch.data[0];
        CFG_INVERT_TRACE: cfg_r.invert_trace <= cfg_ch.data[0];
        CFG_REQ_LEN:      cfg_r.req_len      <= cfg_ch.data[ReqLenW-1:0];
        default:          ;
      endcase
    end
  end

  // Accept a word while the queue has room for its results and for those
  // of the word already in the input register
  assign q_reserved   = q_count + (stage_busy ? QCntW'(2) : QCntW'(0));
  assign in_ch.ready  = (q_reserved <= QAcceptLimit);
  assign word_accept  = in_ch.valid && in_ch.ready;

  deu_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .word_accept (word_accept),
    .word_data   (in_ch.data_word),
    .stage_busy  (stage_busy),
    .push        (push)
  );

  deu_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_ch.valid && out_ch.ready),
    .not_empty (q_not_empty),
    .head      (q_head),
    .count     (q_count)
  );

  // Drive the result channel from the queue head
  assign out_ch.valid     = q_not_empty;
  assign out_ch.kind      = q_head.kind;
  assign out_ch.energy    = q_head.energy;
  assign out_ch.timestamp = q_head.timestamp;
  assign out_ch.vector    = q_head.vector;
  assign out_ch.channel   = q_head.channel;
  assign out_ch.sample    = q_head.sample;
  assign out_ch.last      = q_head.last;

endmodule

`default_nettype wire
